FILE: design/hps_pkg.sv
// Shared types and constants for the host power sequencer.
// No dependencies; imported by host_power_sequencer.
package hps_pkg;

    // Request kind codes on the input channel.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_TICK   = 2'd0;
    localparam kind_t KIND_SWITCH = 2'd1;
    localparam kind_t KIND_HOST   = 2'd2;

    // Configuration register indexes and port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    localparam cfg_index_t CFG_BOOT_WAIT     = 3'd0;
    localparam cfg_index_t CFG_SHUTDOWN_WAIT = 3'd1;
    localparam cfg_index_t CFG_SWITCH_BLINKS = 3'd2;
    localparam cfg_index_t CFG_HOST_BLINKS   = 3'd3;
    localparam cfg_index_t CFG_FINAL_BLINKS  = 3'd4;

    // Counter and register field types.
    typedef logic [6:0] periods_t;
    typedef logic [4:0] blinks_t;
    typedef logic [4:0] ticks_t;
    typedef logic [6:0] loops_t;

endpackage

FILE: design/host_power_sequencer.sv
// Host power sequencer: phase machine, tick and loop counters, output register.
// Depends on hps_pkg for request kinds, register indexes and field types.
//
// Usage:
// Each input request is one 50 ms tick, a switch event or a host event,
// together with the sampled switch level and host status. Every accepted
// request yields exactly one result: power enable, LED drive, busy flag and
// shutdown-armed flag as they stand after that request.
// The sequencer state updates in the cycle a request is accepted, and the
// result sits in an output register, so it appears in the cycle after.
// A new request is accepted every cycle while the output register is empty
// or being drained; if the receiver stalls, in_ready drops until the held
// result is taken, and the result stays unchanged meanwhile.
// Configuration writes use a separate valid/ready channel that is always
// ready; writes to indexes beyond the register list are ignored. Write only
// while the sequencer is idle.
// Reset clears the sequencer to idle with power off, LED off and shutdown
// not armed, and loads the register defaults (boot wait 120, shutdown wait
// 120, switch blinks 4, host blinks 6, final blinks 12).
module host_power_sequencer #(
    parameter int FAST_FIRST_TICKS  = 2,
    parameter int FAST_SECOND_TICKS = 3,
    parameter int SLOW_OFF_TICKS    = 14,
    parameter int SLOW_ON_TICKS     = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  hps_pkg::cfg_index_t cfg_index,
    input  hps_pkg::cfg_data_t  cfg_data,
    // Input request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  hps_pkg::kind_t     kind,
    input  logic               switch_on,
    input  logic               host_running,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               power_enable,
    output logic               led_on,
    output logic               busy_res,
    output logic               shutdown_armed
);

    import hps_pkg::*;

    // Phase codes.
    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_SW_FAST     = 3'd1;
    localparam logic [2:0] PH_HOST_FAST   = 3'd2;
    localparam logic [2:0] PH_FINAL_FAST  = 3'd3;
    localparam logic [2:0] PH_BOOT_WAIT   = 3'd4;
    localparam logic [2:0] PH_REBOOT_WAIT = 3'd5;

    localparam ticks_t FIRST_TICKS  = ticks_t'(FAST_FIRST_TICKS);
    localparam ticks_t SECOND_TICKS = ticks_t'(FAST_SECOND_TICKS);
    localparam ticks_t OFF_TICKS    = ticks_t'(SLOW_OFF_TICKS);
    localparam ticks_t ON_TICKS     = ticks_t'(SLOW_ON_TICKS);

    // Configuration registers.
    periods_t boot_wait_reg;
    periods_t shutdown_wait_reg;
    blinks_t  switch_blinks_reg;
    blinks_t  host_blinks_reg;
    blinks_t  final_blinks_reg;

    // Sequencer state.
    logic [2:0] phase_reg, phase_next;
    ticks_t     tick_reg, tick_next;
    loops_t     loop_reg, loop_next;
    logic       led_reg, led_next;
    logic       power_reg, power_next;
    logic       armed_reg, armed_next;

    // Output register.
    logic out_valid_reg;
    logic power_out_reg, led_out_reg, busy_out_reg, armed_out_reg;

    // Internal control.
    logic       in_accept;
    logic       do_finish;
    logic [2:0] finish_phase;
    ticks_t     tick_dec;
    loops_t     loop_dec;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_wait_reg     <= periods_t'(120);
            shutdown_wait_reg <= periods_t'(120);
            switch_blinks_reg <= blinks_t'(4);
            host_blinks_reg   <= blinks_t'(6);
            final_blinks_reg  <= blinks_t'(12);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BOOT_WAIT:     boot_wait_reg     <= cfg_data;
                CFG_SHUTDOWN_WAIT: shutdown_wait_reg <= cfg_data;
                CFG_SWITCH_BLINKS: switch_blinks_reg <= cfg_data[4:0];
                CFG_HOST_BLINKS:   host_blinks_reg   <= cfg_data[4:0];
                CFG_FINAL_BLINKS:  final_blinks_reg  <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // Next-state logic for one request.
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        loop_next    = loop_reg;
        led_next     = led_reg;
        power_next   = power_reg;
        armed_next   = armed_reg;
        do_finish    = 1'b0;
        finish_phase = phase_reg;
        tick_dec     = (tick_reg != '0) ? tick_reg - 1'b1 : tick_reg;
        loop_dec     = (loop_reg != '0) ? loop_reg - 1'b1 : loop_reg;

        if (phase_reg == PH_IDLE)
        begin
            // Switch events (unless armed) and host events start a fast blink run; an empty run finishes at once.
            if (kind == KIND_SWITCH && !armed_reg)
            begin
                if (switch_blinks_reg == '0)
                begin
                    do_finish    = 1'b1;
                    finish_phase = PH_SW_FAST;
                end
                else
                begin
                    phase_next = PH_SW_FAST;
                    loop_next  = {1'b0, switch_blinks_reg, 1'b0};
                    led_next   = !led_reg;
                    tick_next  = FIRST_TICKS;
                end
            end
            else if (kind == KIND_HOST)
            begin
                if (host_blinks_reg == '0)
                begin
                    do_finish    = 1'b1;
                    finish_phase = PH_HOST_FAST;
                end
                else
                begin
                    phase_next = PH_HOST_FAST;
                    loop_next  = {1'b0, host_blinks_reg, 1'b0};
                    led_next   = !led_reg;
                    tick_next  = FIRST_TICKS;
                end
            end
        end
        else if (kind == KIND_TICK)
        begin
            tick_next = tick_dec;
            if (tick_dec == '0)
            begin
                if (phase_reg == PH_BOOT_WAIT || phase_reg == PH_REBOOT_WAIT)
                begin
                    // Slow period: off half, then on half, then test the host.
                    if (!led_reg)
                    begin
                        led_next  = 1'b1;
                        tick_next = ON_TICKS;
                    end
                    else
                    begin
                        loop_next = loop_dec;
                        if (host_running || loop_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                            if (phase_reg == PH_REBOOT_WAIT && !host_running)
                            begin
                                led_next   = 1'b0;
                                power_next = 1'b0;
                                armed_next = 1'b0;
                            end
                        end
                        else
                        begin
                            led_next  = 1'b0;
                            tick_next = OFF_TICKS;
                        end
                    end
                end
                else
                begin
                    // Fast blink: next half blink, or the run ends.
                    loop_next = loop_dec;
                    if (loop_dec == '0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        led_next  = !led_reg;
                        tick_next = loop_dec[0] ? SECOND_TICKS : FIRST_TICKS;
                    end
                end
            end
        end

        // Decision at the end of a fast blink run.
        if (do_finish)
        begin
            phase_next = finish_phase;
            case (finish_phase)
                PH_SW_FAST:
                begin
                    phase_next = PH_IDLE;
                    if (switch_on && !host_running)
                    begin
                        power_next = 1'b1;
                        if (boot_wait_reg != '0)
                        begin
                            phase_next = PH_BOOT_WAIT;
                            led_next   = 1'b0;
                            tick_next  = OFF_TICKS;
                            loop_next  = boot_wait_reg;
                        end
                    end
                end
                PH_HOST_FAST:
                begin
                    if (armed_reg)
                    begin
                        if (final_blinks_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                            led_next   = 1'b0;
                            power_next = 1'b0;
                            armed_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_FINAL_FAST;
                            loop_next  = {1'b0, final_blinks_reg, 1'b0};
                            led_next   = !led_next;
                            tick_next  = FIRST_TICKS;
                        end
                    end
                    else if (host_running)
                    begin
                        armed_next = 1'b1;
                        led_next   = 1'b0;
                        phase_next = PH_IDLE;
                    end
                    else if (shutdown_wait_reg == '0)
                    begin
                        // No reboot wait: power goes off right away.
                        phase_next = PH_IDLE;
                        led_next   = 1'b0;
                        power_next = 1'b0;
                        armed_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_REBOOT_WAIT;
                        led_next   = 1'b0;
                        tick_next  = OFF_TICKS;
                        loop_next  = shutdown_wait_reg;
                    end
                end
                default:
                begin
                    // End of the final run: power off.
                    phase_next = PH_IDLE;
                    led_next   = 1'b0;
                    power_next = 1'b0;
                    armed_next = 1'b0;
                end
            endcase
        end
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            loop_reg  <= '0;
            led_reg   <= 1'b0;
            power_reg <= 1'b0;
            armed_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            loop_reg  <= loop_next;
            led_reg   <= led_next;
            power_reg <= power_next;
            armed_reg <= armed_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with the state after each request.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            power_out_reg <= power_next;
            led_out_reg   <= led_next;
            busy_out_reg  <= (phase_next != PH_IDLE);
            armed_out_reg <= armed_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign power_enable   = power_out_reg;
    assign led_on         = led_out_reg;
    assign busy_res       = busy_out_reg;
    assign shutdown_armed = armed_out_reg;

    // Every accepted request leaves a result waiting.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    // A running sequence always has a live tick and loop count.
    a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (tick_reg != '0 && loop_reg != '0))
        else $error("busy phase with an exhausted counter");

    // Power is on throughout the boot wait.
    a_boot_power: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BOOT_WAIT) |-> power_reg)
        else $error("boot wait with power off");

    // A tick while idle changes nothing.
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == PH_IDLE && kind == KIND_TICK) |=>
        ($stable(phase_reg) && $stable(led_reg) && $stable(power_reg) &&
         $stable(armed_reg)))
        else $error("idle tick changed the sequencer state");

endmodule
